>>> src/adcss_pkg.sv
`default_nettype none

package adcss_pkg;

  // Number of analog inputs that the channel mask can select from.
  localparam int unsigned NumInputs = 8;
  // Largest number of rounds that one buffer pass may take.
  localparam int unsigned MaxDepth = 32;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgChannelMask  = 2'd0,
    CfgNumChannels  = 2'd1,
    CfgDepth        = 2'd2,
    CfgCircularMode = 2'd3
  } cfg_idx_e;

  // Input item function codes.
  typedef enum logic {
    FuncStart = 1'b0,
    FuncDone  = 1'b1
  } func_e;

  // Configuration register contents.
  typedef struct packed {
    logic [7:0] channel_mask;
    logic [3:0] round_size;
    logic [5:0] depth;
    logic       circular_mode;
  } cfg_t;

  // One input item.
  typedef struct packed {
    logic       func;
    logic [9:0] sample;
  } item_t;

  // One result item.
  typedef struct packed {
    logic       write_valid;
    logic [7:0] write_index;
    logic [9:0] write_data;
    logic [2:0] next_channel;
    logic       start_conversion;
    logic       half_event;
    logic       full_event;
  } res_t;

  // Returns the position of the k-th set bit of the mask, or 0 if there is none.
  function automatic logic [2:0] pick_channel(logic [7:0] mask, logic [2:0] k);
    logic [3:0] seen;
    logic [2:0] chan;
    logic       found;
    seen  = '0;
    chan  = '0;
    found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (i < NumInputs && mask[i] && !found) begin
        if (seen == {1'b0, k}) begin
          chan  = 3'(i);
          found = 1'b1;
        end
        seen = seen + 4'd1;
      end
    end
    return chan;
  endfunction

endpackage

`default_nettype wire

>>> src/adc_scan_sequencer.sv
// Channel  Handshake                 Payload
// in       in_valid_i / in_ready_o   func_i, sample_i
// out      out_valid_o / out_ready_i write_valid_o .. full_event_o
// cfg      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// An accepted item sits in the input register and crosses the scan logic into
// the result register once that register is free or its result is taken. One
// item is accepted per cycle unless the output stalls; the result register sets
// the pace. A stalled output holds the result while one more item waits in the
// input register. Reset returns the configuration to its defaults and idles the scan.
`default_nettype none

module adc_scan_sequencer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       func_i,
  input  wire logic [9:0] sample_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            write_valid_o,
  output logic [7:0]      write_index_o,
  output logic [9:0]      write_data_o,
  output logic [2:0]      next_channel_o,
  output logic            start_conversion_o,
  output logic            half_event_o,
  output logic            full_event_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);
  import adcss_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  advance;
  res_t  res;

  adcss_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  adcss_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .sample_i     (sample_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  adcss_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign write_valid_o      = res.write_valid;
  assign write_index_o      = res.write_index;
  assign write_data_o       = res.write_data;
  assign next_channel_o     = res.next_channel;
  assign start_conversion_o = res.start_conversion;
  assign half_event_o       = res.half_event;
  assign full_event_o       = res.full_event;

endmodule

`default_nettype wire

>>> src/adcss_cfg_regs.sv
`default_nettype none

module adcss_cfg_regs (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [7:0]        cfg_data_i,
  output logic                   cfg_ready_o,
  output adcss_pkg::cfg_t        cfg_o
);
  import adcss_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Registers are always ready to take a write.
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Decode the register index of a write transaction.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgChannelMask:  cfg_d.channel_mask  = cfg_data_i;
        CfgNumChannels:  cfg_d.round_size    = cfg_data_i[3:0];
        CfgDepth:        cfg_d.depth         = cfg_data_i[5:0];
        CfgCircularMode: cfg_d.circular_mode = cfg_data_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_mask  <= 8'd1;
      cfg_q.round_size    <= 4'd1;
      cfg_q.depth         <= 6'd1;
      cfg_q.circular_mode <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

>>> src/adcss_in_stage.sv
`default_nettype none

module adcss_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              func_i,
  input  wire logic [9:0]        sample_i,
  input  wire logic              advance_i,
  output logic                   item_valid_o,
  output adcss_pkg::item_t       item_o
);
  import adcss_pkg::*;

  logic  valid_q;
  logic  valid_d;
  item_t item_q;

  // The register takes a new item when empty or when its item moves on.
  assign in_ready_o   = !valid_q || advance_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload holds without reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.func   <= func_i;
      item_q.sample <= sample_i;
    end
  end

endmodule

`default_nettype wire

>>> src/adcss_core.sv
`default_nettype none

module adcss_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire adcss_pkg::cfg_t   cfg_i,
  input  wire logic              item_valid_i,
  input  wire adcss_pkg::item_t  item_i,
  output logic                   advance_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output adcss_pkg::res_t        res_o
);
  import adcss_pkg::*;

  localparam logic [5:0] DepthLimit = 6'(MaxDepth > 63 ? 63 : MaxDepth);

  logic [8:0] pos_q,  pos_d;
  logic [2:0] rch_q,  rch_d;
  logic [5:0] rcnt_q, rcnt_d;
  logic       run_q,  run_d;
  logic       out_valid_q, out_valid_d;
  res_t       res_q,  res_d;

  logic [3:0] nc;
  logic [5:0] dp;
  logic [3:0] rch_inc;
  logic [5:0] rcnt_inc;
  logic       round_close;
  logic       buf_full;

  // An item moves into the result register when that register is free.
  assign advance_o   = item_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // Clamp the round size and the buffer depth to their legal ranges.
  always_comb begin
    if (cfg_i.round_size == 4'd0) begin
      nc = 4'd1;
    end else if (cfg_i.round_size > 4'd8) begin
      nc = 4'd8;
    end else begin
      nc = cfg_i.round_size;
    end
    if (cfg_i.depth == 6'd0) begin
      dp = 6'd1;
    end else if (cfg_i.depth > DepthLimit) begin
      dp = DepthLimit;
    end else begin
      dp = cfg_i.depth;
    end
  end

  // Round and buffer bookkeeping for a conversion-done item.
  assign rch_inc     = {1'b0, rch_q} + 4'd1;
  assign rcnt_inc    = rcnt_q + 6'd1;
  assign round_close = rch_inc >= nc;
  assign buf_full    = round_close && (rcnt_inc >= dp);

  // Next scan state and the result of the item in the input register.
  always_comb begin
    pos_d  = pos_q;
    rch_d  = rch_q;
    rcnt_d = rcnt_q;
    run_d  = run_q;
    res_d  = '0;
    if (item_i.func == FuncStart) begin
      pos_d                  = '0;
      rch_d                  = '0;
      rcnt_d                 = '0;
      run_d                  = 1'b1;
      res_d.next_channel     = pick_channel(cfg_i.channel_mask, 3'd0);
      res_d.start_conversion = 1'b1;
    end else if (run_q) begin
      res_d.write_valid = 1'b1;
      res_d.write_index = pos_q[7:0];
      res_d.write_data  = item_i.sample;
      pos_d             = pos_q + 9'd1;
      if (round_close) begin
        rch_d            = '0;
        rcnt_d           = rcnt_inc;
        res_d.half_event = cfg_i.circular_mode && (rcnt_inc == (dp >> 1));
      end else begin
        rch_d = rch_inc[2:0];
      end
      if (buf_full) begin
        res_d.full_event = 1'b1;
        pos_d            = '0;
        rcnt_d           = '0;
        if (cfg_i.circular_mode) begin
          res_d.next_channel     = pick_channel(cfg_i.channel_mask, 3'd0);
          res_d.start_conversion = 1'b1;
        end else begin
          run_d = 1'b0;
        end
      end else begin
        res_d.next_channel     = pick_channel(cfg_i.channel_mask, rch_d);
        res_d.start_conversion = 1'b1;
      end
    end
  end

  // Result register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      rch_q       <= '0;
      rcnt_q      <= '0;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance_o) begin
        pos_q  <= pos_d;
        rch_q  <= rch_d;
        rcnt_q <= rcnt_d;
        run_q  <= run_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

>>> src/adcss_checker.sv
`default_nettype none

module adcss_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       write_valid_o,
  input wire logic [7:0] write_index_o,
  input wire logic [9:0] write_data_o,
  input wire logic [2:0] next_channel_o,
  input wire logic       start_conversion_o,
  input wire logic       half_event_o,
  input wire logic       full_event_o
);

  // A result transaction waits until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  // Half and full events never come with the same sample.
  a_half_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(half_event_o && full_event_o))
    else $error("half and full event together");

  // A half event closes a round and always launches the next conversion.
  a_half_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && half_event_o |-> write_valid_o && start_conversion_o)
    else $error("half event without write and new conversion");

  // Without a write the buffer fields read zero.
  a_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_valid_o |->
      write_index_o == 8'd0 && write_data_o == 10'd0 && !full_event_o)
    else $error("write fields set without a write");

  // Without a new conversion the channel reads zero.
  a_no_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !start_conversion_o |-> next_channel_o == 3'd0)
    else $error("channel set without a conversion");

endmodule

bind adc_scan_sequencer adcss_checker u_adcss_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .write_valid_o      (write_valid_o),
  .write_index_o      (write_index_o),
  .write_data_o       (write_data_o),
  .next_channel_o     (next_channel_o),
  .start_conversion_o (start_conversion_o),
  .half_event_o       (half_event_o),
  .full_event_o       (full_event_o)
);

`default_nettype wire

>>> tb/adc_scan_sequencer_tb.sv
module adc_scan_sequencer_tb;
  import adcss_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned MaxChannels = 8;
  localparam int unsigned ReportLimit = 10;

  typedef struct {
    func_e      op;
    logic [9:0] value;
    bit         drain;
  } scan_item_t;

  typedef struct {
    cfg_idx_e   idx;
    logic [7:0] data;
  } reg_write_t;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_func   = 1'b0;
  logic [9:0] in_sample = '0;
  logic       out_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data  = '0;

  logic       in_ready_o;
  logic       out_valid_o;
  logic       write_valid_o;
  logic [7:0] write_index_o;
  logic [9:0] write_data_o;
  logic [2:0] next_channel_o;
  logic       start_conversion_o;
  logic       half_event_o;
  logic       full_event_o;
  logic       cfg_ready_o;

  // Pending stimulus, filled by the sequence below and drained by the drivers.
  scan_item_t item_q[$];
  reg_write_t reg_q[$];
  // Sequencer outcomes predicted for accepted items, oldest first.
  res_t       predicted_q[$];

  int n_accepted = 0;
  int n_results  = 0;
  int mismatches = 0;
  int idle_pct   = 33;
  int cycle_count;

  // Shadow copy of the configuration registers.
  logic [7:0] shadow_mask  = 8'h01;
  logic [3:0] shadow_nch   = 4'd1;
  logic [5:0] shadow_depth = 6'd1;
  logic       shadow_circ  = 1'b0;

  // Shadow copy of the scan state.
  logic [8:0]  pos_q    = '0;
  int unsigned rchan_q  = 0;
  logic [5:0]  rcount_q = '0;
  bit          scanning = 1'b0;

  adc_scan_sequencer u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .func_i             (in_func),
    .sample_i           (in_sample),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .write_valid_o      (write_valid_o),
    .write_index_o      (write_index_o),
    .write_data_o       (write_data_o),
    .next_channel_o     (next_channel_o),
    .start_conversion_o (start_conversion_o),
    .half_event_o       (half_event_o),
    .full_event_o       (full_event_o),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  // Channel of the k-th enabled input in the mask; channel 0 when there are too few.
  function automatic logic [2:0] nth_enabled(logic [7:0] mask, int unsigned k);
    int unsigned seen;
    seen = 0;
    for (int i = 0; i < NumInputs && i < 8; i++) begin
      if (mask[i]) begin
        if (seen == k) return 3'(i);
        seen++;
      end
    end
    return 3'd0;
  endfunction

  // Advances the shadow scan state by one item and returns the outcome it causes.
  function automatic res_t advance_scan(func_e op, logic [9:0] value);
    res_t        r;
    int unsigned nc;
    int unsigned dp;
    r = '0;
    if (op == FuncStart) begin
      pos_q              = '0;
      rchan_q            = 0;
      rcount_q           = '0;
      scanning           = 1'b1;
      r.next_channel     = nth_enabled(shadow_mask, 0);
      r.start_conversion = 1'b1;
    end else if (scanning) begin
      // Out-of-range settings are clamped to the usable range.
      nc = (shadow_nch == 0) ? 1 : (shadow_nch > MaxChannels) ? MaxChannels : shadow_nch;
      dp = (shadow_depth == 0) ? 1 : (shadow_depth > MaxDepth) ? MaxDepth : shadow_depth;
      r.write_valid = 1'b1;
      r.write_index = pos_q[7:0];
      r.write_data  = value;
      pos_q         = pos_q + 9'd1;
      rchan_q++;
      if (rchan_q >= nc) begin
        rchan_q  = 0;
        rcount_q = rcount_q + 6'd1;
        if (shadow_circ && rcount_q == dp / 2) r.half_event = 1'b1;
      end
      if (rchan_q == 0 && rcount_q >= dp) begin
        // Buffer full: circular mode wraps and keeps converting, linear mode stops.
        r.full_event = 1'b1;
        pos_q        = '0;
        rcount_q     = '0;
        if (shadow_circ) begin
          r.next_channel     = nth_enabled(shadow_mask, 0);
          r.start_conversion = 1'b1;
        end else begin
          scanning = 1'b0;
        end
      end else begin
        r.next_channel     = nth_enabled(shadow_mask, rchan_q);
        r.start_conversion = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic string show(res_t r);
    return $sformatf("wv=%0b idx=%0d data=%0d ch=%0d sc=%0b half=%0b full=%0b",
                     r.write_valid, r.write_index, r.write_data, r.next_channel,
                     r.start_conversion, r.half_event, r.full_event);
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= ReportLimit) $display("%s", msg);
  endtask

  // Driver for the configuration and input channels.
  always @(posedge clk_i) begin
    scan_item_t it;
    reg_write_t w;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      // Configuration transaction.
      if (cfg_valid && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index))
          CfgChannelMask:  shadow_mask  = cfg_data;
          CfgNumChannels:  shadow_nch   = cfg_data[3:0];
          CfgDepth:        shadow_depth = cfg_data[5:0];
          CfgCircularMode: shadow_circ  = cfg_data[0];
          default: ;
        endcase
      end
      if (!cfg_valid || cfg_ready_o) begin
        if (reg_q.size() > 0) begin
          w = reg_q.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= w.idx;
          cfg_data  <= w.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end

      // Input transaction; a drain item waits until every outcome has come back.
      if (in_valid && in_ready_o) begin
        predicted_q.push_back(advance_scan(func_e'(in_func), in_sample));
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || in_ready_o) begin
        if (item_q.size() > 0 && $urandom_range(99) >= idle_pct &&
            (!item_q[0].drain || (!in_valid && n_accepted == n_results))) begin
          it = item_q.pop_front();
          in_valid  <= 1'b1;
          in_func   <= it.op;
          in_sample <= it.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest prediction.
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        got.write_valid      = write_valid_o;
        got.write_index      = write_index_o;
        got.write_data       = write_data_o;
        got.next_channel     = next_channel_o;
        got.start_conversion = start_conversion_o;
        got.half_event       = half_event_o;
        got.full_event       = full_event_o;
        n_results <= n_results + 1;
        if (predicted_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result: got %s", show(got)));
        end else begin
          want = predicted_q.pop_front();
          if (got.write_valid !== want.write_valid ||
              got.write_index !== want.write_index ||
              got.write_data !== want.write_data ||
              got.next_channel !== want.next_channel ||
              got.start_conversion !== want.start_conversion ||
              got.half_event !== want.half_event ||
              got.full_event !== want.full_event) begin
            flag_mismatch($sformatf("mismatch at result %0d: expected %s, got %s",
                                    n_results, show(want), show(got)));
          end
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Watchdog.
  initial begin
    for (cycle_count = 0; cycle_count < CycleLimit; cycle_count++) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [9:0] noisy_sample();
    case ($urandom_range(9))
      0: return 10'h000;
      1: return 10'h3FF;
      default: return 10'($urandom);
    endcase
  endfunction

  task automatic queue_item(func_e op, logic [9:0] value, bit drain = 1'b0);
    scan_item_t it;
    it.op    = op;
    it.value = value;
    it.drain = drain;
    item_q.push_back(it);
  endtask

  // Waits until every item is accepted and every outcome has come back.
  task automatic settle();
    while (item_q.size() != 0 || in_valid || n_results != n_accepted) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  // Writes all four registers; unused data bits carry random values.
  task automatic program_regs(logic [7:0] mask, logic [3:0] nch, logic [5:0] dp, logic circ);
    reg_q.push_back('{CfgChannelMask, mask});
    reg_q.push_back('{CfgNumChannels, {4'($urandom), nch}});
    reg_q.push_back('{CfgDepth, {2'($urandom), dp}});
    reg_q.push_back('{CfgCircularMode, {7'($urandom), circ}});
    while (reg_q.size() != 0 || cfg_valid) @(negedge clk_i);
  endtask

  // Stimulus sequence. All queue updates happen on the falling edge.
  initial begin
    logic [7:0]  mask;
    logic [3:0]  nch;
    logic [5:0]  dp;
    logic        circ;
    int unsigned enc;
    int unsigned edp;
    int unsigned planned;
    int unsigned extra;
    int unsigned planned_total;
    int          phase;

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset configuration: a sample while idle is ignored, depth of one gives no half event.
    queue_item(FuncDone, 10'h3FF);
    queue_item(FuncStart, 10'h000);
    queue_item(FuncDone, 10'h000);
    queue_item(FuncDone, 10'h2AA);
    settle();

    // Too few mask bits for three channels, circular wrap, restart while running.
    program_regs(8'h81, 4'd3, 6'd2, 1'b1);
    queue_item(FuncStart, 10'h3FF);
    queue_item(FuncDone, 10'h3FF);
    queue_item(FuncDone, 10'h000);
    queue_item(FuncDone, 10'h155);
    queue_item(FuncDone, 10'h2AA);
    queue_item(FuncDone, 10'h3FF);
    queue_item(FuncDone, 10'h001);
    queue_item(FuncDone, 10'h200);
    queue_item(FuncDone, 10'h0FF);
    queue_item(FuncStart, 10'h000);
    settle();

    // Empty mask, channel count above range, depth of zero, linear stop.
    program_regs(8'h00, 4'hF, 6'd0, 1'b0);
    queue_item(FuncStart, noisy_sample());
    for (int i = 0; i < 8; i++) queue_item(FuncDone, noisy_sample());
    queue_item(FuncDone, 10'h3FF);
    settle();

    // Random phases: mostly well-formed scans with random content, some noise.
    planned_total = 0;
    for (phase = 0; planned_total < 850; phase++) begin
      if (phase == 2) begin
        mask = 8'hFF;
        nch  = 4'd8;
        dp   = 6'd32;
        circ = 1'b1;
      end else if (phase == 5) begin
        mask = 8'($urandom);
        nch  = 4'd1;
        dp   = 6'd63;
        circ = 1'b0;
      end else begin
        case ($urandom_range(9))
          0: mask = 8'h00;
          1: mask = 8'hFF;
          default: mask = 8'($urandom);
        endcase
        nch  = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(4, 1));
        dp   = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(6, 1));
        circ = 1'($urandom_range(1));
      end
      enc = (nch == 0) ? 1 : (nch > MaxChannels) ? MaxChannels : nch;
      edp = (dp == 0) ? 1 : (dp > MaxDepth) ? MaxDepth : dp;
      program_regs(mask, nch, dp, circ);

      // The largest scan runs with no idling on either side.
      idle_pct = (phase == 2) ? 0 : 33;
      planned  = enc * edp;
      extra    = $urandom_range(planned / 2 + 2);

      // Skipping the start now and then continues the previous scan under new settings.
      if (phase == 2 || $urandom_range(6) != 0) queue_item(FuncStart, noisy_sample());
      for (int i = 0; i < planned + extra; i++) begin
        queue_item((phase != 2 && $urandom_range(99) < 4) ? FuncStart : FuncDone,
                   noisy_sample(), (phase == 2 && i == 128) || $urandom_range(199) == 0);
      end
      planned_total += planned + extra + 1;
      settle();
    end

    if (mismatches == 0 && predicted_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> adc_scan_sequencer.f
src/adcss_pkg.sv
src/adcss_cfg_regs.sv
src/adcss_in_stage.sv
src/adcss_core.sv
src/adc_scan_sequencer.sv
src/adcss_checker.sv
tb/adc_scan_sequencer_tb.sv
